// File: hdl/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg
// shared constants, types and codes for the ambiguous median cost block
// ----------------------------------------------------------------------------
package amc_pkg;

  localparam int MAX_SYMBOLS  = 8;
  localparam int COST_W       = 16;
  // sum of three costs of at most COST_W bits each
  localparam int SUM_W        = COST_W + 2;
  localparam int MASK_W       = 8;
  localparam int ROWS         = (MAX_SYMBOLS < MASK_W) ? MAX_SYMBOLS : MASK_W;
  localparam int SYM_W        = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int NUM_W        = $clog2(MAX_SYMBOLS + 1);
  localparam int MIN_COST_W   = 18;
  localparam int MIN_COST_MAX = (1 << MIN_COST_W) - 1;
  localparam int ALPHA_W      = 4;
  localparam int ALPHA_RESET  = 5;
  localparam int ALPHA_MIN    = 2;

  typedef logic [COST_W-1:0] cost_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [MASK_W-1:0] mask_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_QUERY2 = 2'd1,
    OP_QUERY3 = 2'd2
  } op_t;

  // per-stage load strobes of the query pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

endpackage

// File: hdl/ambiguous_median_cost_top.sv
// ----------------------------------------------------------------------------
// ambiguous_median_cost_top
// median cost of two or three ambiguity masks over a loaded cost table
// ----------------------------------------------------------------------------
// a query word passes through five registers (input, lane minimum, lane sum,
// merge minimum, output) before its result; one word per cycle sustained
// while out_ready holds, set by the one-lane-per-candidate pipeline. a load
// word writes the table at acceptance and gives no result.
// reset empties the pipeline and sets alphabet_size to 5; the cost table
// is not cleared.
module ambiguous_median_cost_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_operation,
  input  logic [2:0]                       in_table_row,
  input  logic [2:0]                       in_table_column,
  input  logic [15:0]                      in_entry_cost,
  input  logic [7:0]                       in_mask_a,
  input  logic [7:0]                       in_mask_b,
  input  logic [7:0]                       in_mask_c,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [17:0]                      out_min_cost,
  output logic [7:0]                       out_median_mask,
  output logic                             out_empty_mask_error,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [amc_pkg::ALPHA_W-1:0]      cfg_data
);

  localparam int N = amc_pkg::MAX_SYMBOLS;

  amc_pkg::cost_t table_r [N][N];
  logic [amc_pkg::ALPHA_W-1:0] alpha_r;
  logic [amc_pkg::NUM_W-1:0]   num;
  amc_pkg::mask_t              row_act;
  logic [N-1:0]                lane_act;

  logic v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc, is_query, is_load, use_c_in;
  amc_pkg::adv_t adv;

  amc_pkg::mask_t mask_a0_r, mask_b0_r, mask_c0_r;
  logic           use_c0_r;
  logic           err1_r, err2_r, err_nxt;

  amc_pkg::sum_t  sums [N];

  assign cfg_ready = 1'b1;

  // ready ripples back from the output register
  assign rdy4     = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = !v0_r || rdy1;
  assign in_acc   = in_valid && in_ready;

  assign adv.s1 = v0_r && rdy1;
  assign adv.s2 = v1_r && rdy2;
  assign adv.s3 = v2_r && rdy3;
  assign adv.s4 = v3_r && rdy4;

  always_comb begin
    is_query = 1'b0;
    is_load  = 1'b0;
    use_c_in = 1'b0;
    unique case (amc_pkg::op_t'(in_operation))
      amc_pkg::OP_LOAD:   is_load = 1'b1;
      amc_pkg::OP_QUERY2: is_query = 1'b1;
      amc_pkg::OP_QUERY3: begin
        is_query = 1'b1;
        use_c_in = 1'b1;
      end
      default: ;
    endcase
  end

  // active symbol count, clamped to the supported range
  always_comb begin
    if (int'(alpha_r) < amc_pkg::ALPHA_MIN) begin
      num = amc_pkg::NUM_W'(amc_pkg::ALPHA_MIN);
    end else if (int'(alpha_r) > N) begin
      num = amc_pkg::NUM_W'(N);
    end else begin
      num = amc_pkg::NUM_W'(alpha_r);
    end
    for (int s = 0; s < amc_pkg::MASK_W; s++) begin
      row_act[s] = (s < amc_pkg::ROWS) && (s < int'(num));
    end
    for (int c = 0; c < N; c++) begin
      lane_act[c] = c < int'(num);
    end
    err_nxt = !(|(mask_a0_r & row_act)) || !(|(mask_b0_r & row_act))
           || (use_c0_r && !(|(mask_c0_r & row_act)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= amc_pkg::ALPHA_W'(amc_pkg::ALPHA_RESET);
    end else if (cfg_valid && cfg_ready) begin
      alpha_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_load && (int'(in_table_row) < N) && (int'(in_table_column) < N)) begin
      table_r[amc_pkg::SYM_W'(in_table_row)][amc_pkg::SYM_W'(in_table_column)]
        <= amc_pkg::COST_W'(in_entry_cost);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) v0_r <= in_acc && is_query;
      if (rdy1)     v1_r <= v0_r;
      if (rdy2)     v2_r <= v1_r;
      if (rdy3)     v3_r <= v2_r;
      if (rdy4)     out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_query) begin
      mask_a0_r <= in_mask_a;
      mask_b0_r <= in_mask_b;
      mask_c0_r <= in_mask_c;
      use_c0_r  <= use_c_in;
    end
    if (adv.s1) err1_r <= err_nxt;
    if (adv.s2) err2_r <= err1_r;
  end

  for (genvar c = 0; c < N; c++) begin : g_lane
    amc_pkg::cost_t col [amc_pkg::ROWS];
    for (genvar s = 0; s < amc_pkg::ROWS; s++) begin : g_col
      assign col[s] = table_r[s][c];
    end
    amc_lane u_lane (
      .clk     (clk),
      .adv     (adv),
      .col     (col),
      .mask_a  (mask_a0_r),
      .mask_b  (mask_b0_r),
      .mask_c  (mask_c0_r),
      .use_c   (use_c0_r),
      .row_act (row_act),
      .sum_r   (sums[c])
    );
  end

  amc_merge u_merge (
    .clk        (clk),
    .adv        (adv),
    .sums       (sums),
    .lane_act   (lane_act),
    .err        (err2_r),
    .min_cost_r (out_min_cost),
    .median_r   (out_median_mask),
    .err_r      (out_empty_mask_error)
  );

  assign out_valid = out_valid_r;

endmodule

// File: hdl/amc_lane.sv
// ----------------------------------------------------------------------------
// amc_lane
// one candidate symbol: least cost per mask over its table column, then sum
// ----------------------------------------------------------------------------
module amc_lane (
  input  logic               clk,
  input  amc_pkg::adv_t      adv,
  input  amc_pkg::cost_t     col [amc_pkg::ROWS],
  input  amc_pkg::mask_t     mask_a,
  input  amc_pkg::mask_t     mask_b,
  input  amc_pkg::mask_t     mask_c,
  input  logic               use_c,
  input  amc_pkg::mask_t     row_act,
  output amc_pkg::sum_t      sum_r
);

  amc_pkg::cost_t min_a_r, min_b_r, min_c_r;
  amc_pkg::cost_t min_a_nxt, min_b_nxt, min_c_nxt;
  amc_pkg::sum_t  sum_nxt;

  function automatic amc_pkg::cost_t least(amc_pkg::mask_t m);
    amc_pkg::cost_t best;
    best = '1;
    for (int s = 0; s < amc_pkg::ROWS; s++) begin
      if (m[s] && (col[s] < best)) begin
        best = col[s];
      end
    end
    return best;
  endfunction

  always_comb begin
    min_a_nxt = least(mask_a & row_act);
    min_b_nxt = least(mask_b & row_act);
    // unused third mask adds nothing
    min_c_nxt = use_c ? least(mask_c & row_act) : '0;
    sum_nxt   = amc_pkg::SUM_W'(min_a_r) + amc_pkg::SUM_W'(min_b_r)
              + amc_pkg::SUM_W'(min_c_r);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      min_a_r <= min_a_nxt;
      min_b_r <= min_b_nxt;
      min_c_r <= min_c_nxt;
    end
    if (adv.s2) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// File: hdl/amc_merge.sv
// ----------------------------------------------------------------------------
// amc_merge
// least sum over the active lanes, then the median mask and saturation
// ----------------------------------------------------------------------------
module amc_merge (
  input  logic                                clk,
  input  amc_pkg::adv_t                       adv,
  input  amc_pkg::sum_t                       sums [amc_pkg::MAX_SYMBOLS],
  input  logic [amc_pkg::MAX_SYMBOLS-1:0]     lane_act,
  input  logic                                err,
  output logic [amc_pkg::MIN_COST_W-1:0]      min_cost_r,
  output amc_pkg::mask_t                      median_r,
  output logic                                err_r
);

  localparam int SAT_W = (amc_pkg::SUM_W > amc_pkg::MIN_COST_W) ?
                         amc_pkg::SUM_W : amc_pkg::MIN_COST_W;

  amc_pkg::sum_t                   best_nxt, best_r;
  amc_pkg::sum_t                   sums_r [amc_pkg::MAX_SYMBOLS];
  logic [amc_pkg::MAX_SYMBOLS-1:0] act_r;
  logic                            err3_r;
  logic [SAT_W-1:0]                best_ext;
  logic [amc_pkg::MIN_COST_W-1:0]  min_cost_nxt;
  amc_pkg::mask_t                  median_nxt;
  amc_pkg::mask_t                  hit;

  always_comb begin
    // inactive lanes never win: all-ones is above any real sum
    best_nxt = '1;
    for (int c = 0; c < amc_pkg::MAX_SYMBOLS; c++) begin
      if (lane_act[c] && (sums[c] < best_nxt)) begin
        best_nxt = sums[c];
      end
    end
  end

  for (genvar i = 0; i < amc_pkg::MASK_W; i++) begin : g_hit
    if (i < amc_pkg::MAX_SYMBOLS) begin : g_on
      assign hit[i] = act_r[i] && (sums_r[i] == best_r);
    end else begin : g_off
      assign hit[i] = 1'b0;
    end
  end

  always_comb begin
    best_ext = SAT_W'(best_r);
    if (best_ext > SAT_W'(amc_pkg::MIN_COST_MAX)) begin
      min_cost_nxt = amc_pkg::MIN_COST_W'(amc_pkg::MIN_COST_MAX);
    end else begin
      min_cost_nxt = best_ext[amc_pkg::MIN_COST_W-1:0];
    end
    median_nxt = hit;
    if (err3_r) begin
      min_cost_nxt = '0;
      median_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      best_r <= best_nxt;
      sums_r <= sums;
      act_r  <= lane_act;
      err3_r <= err;
    end
    if (adv.s4) begin
      min_cost_r <= min_cost_nxt;
      median_r   <= median_nxt;
      err_r      <= err3_r;
    end
  end

endmodule
